/* src/nmea_rmc_gga_sentence_parser_macros.svh */
// ----------------------------------------------------------------------------
// NMEA sentence parser assertion macros
// Assertion shorthands for the sentence parser back end.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_GGA_SENTENCE_PARSER_MACROS_SVH
`define NMEA_RMC_GGA_SENTENCE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NRGP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nrgp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NRGP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nrgp: next-cycle check failed");

`endif

/* src/nrgp_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA sentence parser package
// Constants, codes and transaction types shared by the parser modules.
// ----------------------------------------------------------------------------
package nrgp_pkg;

   // Sentence limits.
   localparam int MAX_SENTENCE_LEN  = 128;
   localparam int MAX_FIELDS        = 32;
   localparam int POS_W             = $clog2(MAX_SENTENCE_LEN + 1);
   localparam int FIELD_W           = $clog2(MAX_FIELDS);

   // Queue depths (powers of two so the pointers wrap on their own).
   localparam int SUM_DEPTH = 4;
   localparam int SUM_PTR_W = $clog2(SUM_DEPTH);
   localparam int SUM_CNT_W = $clog2(SUM_DEPTH + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // Characters of interest.
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_G     = 8'h47;

   // Field numbers.
   localparam logic [FIELD_W-1:0] FLD_TIME   = FIELD_W'(1);
   localparam logic [FIELD_W-1:0] FLD_STATUS = FIELD_W'(2);
   localparam logic [FIELD_W-1:0] FLD_LAT    = FIELD_W'(3);
   localparam logic [FIELD_W-1:0] FLD_NS     = FIELD_W'(4);
   localparam logic [FIELD_W-1:0] FLD_LON    = FIELD_W'(5);
   localparam logic [FIELD_W-1:0] FLD_EW     = FIELD_W'(6);
   localparam logic [FIELD_W-1:0] FLD_SPEED  = FIELD_W'(7);
   localparam logic [FIELD_W-1:0] FLD_COURSE = FIELD_W'(8);
   localparam logic [FIELD_W-1:0] FLD_DATE   = FIELD_W'(9);

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_RMC     = 2'd1,
      KIND_GGA     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REC_POSITION = 2'd0,
      REC_MOTION   = 2'd1,
      REC_ALTITUDE = 2'd2,
      REC_REJECT   = 2'd3
   } record_type;

   typedef enum logic [1:0] {
      STAT_OK           = 2'd0,
      STAT_UNKNOWN_TYPE = 2'd1,
      STAT_INVALID_FIX  = 2'd2
   } status_type;

   // Everything a finished sentence leaves behind.
   typedef struct packed {
      kind_type             kind;
      logic                 fix;
      logic [1:0][14:0]     whole;
      logic [1:0][16:0]     frac;
      logic [1:0][2:0]      fdig;
      logic [1:0][7:0]      hemi;
      logic [19:0]          speed;
      logic [15:0]          course;
      logic [11:0][3:0]     dt;
      logic [20:0]          alt;
      logic                 alt_neg;
      logic [6:0]           sats;
   } sum_type;

   // Head of the sentence queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      sum_type data;
   } sum_port_type;

   // One result transaction.
   typedef struct packed {
      record_type         record;
      status_type         status;
      logic signed [28:0] word_a;
      logic [15:0]        word_b;
      logic [6:0]         word_c;
      logic [9:0]         word_d;
      logic [6:0]         word_e;
      logic [6:0]         word_f;
      logic [7:0]         word_g;
      logic [7:0]         word_h;
      logic               last;
   } rec_type;

endpackage

/* src/nrgp_front.sv */
// ----------------------------------------------------------------------------
// NMEA sentence parser front end
// Splits the character stream into fields, accumulates the numbers and
// queues a summary of every finished sentence.
// ----------------------------------------------------------------------------
module nrgp_front
   import nrgp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [7:0]   req_data_byte,
   input  logic         req_end_of_sentence,
   output sum_port_type sum_out,
   input  logic         sum_pop
);

   // Whole degrees and minutes digit, saturating.
   function automatic logic [14:0] whole_digit(logic [14:0] w, logic [3:0] d);
      logic [18:0] r;
      r = 19'(w) * 19'd10 + 19'(d);
      return (r > 19'd32767) ? 15'd32767 : r[14:0];
   endfunction

   // Satellite count digit, saturating.
   function automatic logic [6:0] sats_digit(logic [6:0] s, logic [3:0] d);
      logic [10:0] r;
      r = 11'(s) * 11'd10 + 11'(d);
      return (r > 11'd127) ? 7'd127 : r[6:0];
   endfunction

   // Digit into a value with two kept fraction digits, saturating.
   function automatic logic [19:0] hund_digit(logic [19:0] v, logic [3:0] d, logic pt,
                                              logic [2:0] fl, logic [19:0] limit);
      logic [24:0] r;
      r = 25'(v);
      if (!pt) begin
         r = r * 25'd10 + 25'(d) * 25'd100;
      end else if (fl == 3'd0) begin
         r = r + 25'(d) * 25'd10;
      end else if (fl == 3'd1) begin
         r = r + 25'(d);
      end
      return (r > 25'(limit)) ? limit : r[19:0];
   endfunction

   // Digit into a value with one kept fraction digit, saturating.
   function automatic logic [20:0] tenth_digit(logic [20:0] v, logic [3:0] d, logic pt,
                                               logic [2:0] fl);
      logic [25:0] r;
      r = 26'(v);
      if (!pt) begin
         r = r * 26'd10 + 26'(d) * 26'd10;
      end else if (fl == 3'd0) begin
         r = r + 26'(d);
      end
      return (r > 26'd999999) ? 21'd999999 : r[20:0];
   endfunction

   sum_type              sum_ff, sum_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [FIELD_W-1:0]   field_ff, field_in;
   logic [6:0]           cif_ff, cif_in;
   logic                 point_ff, point_in;
   logic [2:0]           flen_ff, flen_in;
   logic [3:0]           dig;
   logic                 accept;

   sum_type              q_mem [SUM_DEPTH];
   logic [SUM_PTR_W-1:0] q_wr_ff, q_rd_ff;
   logic [SUM_CNT_W-1:0] q_cnt_ff;
   logic                 q_push, q_pop;

   assign full   = (q_cnt_ff == SUM_CNT_W'(SUM_DEPTH));
   assign accept = push && !full;
   assign dig    = (req_data_byte >= CH_ZERO && req_data_byte <= CH_NINE) ?
                   4'(req_data_byte - CH_ZERO) : 4'd0;

   // Per-character update of the sentence state.
   always_comb begin
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      field_in = field_ff;
      cif_in   = cif_ff;
      point_in = point_ff;
      flen_in  = flen_ff;
      if (pos_ff < POS_W'(MAX_SENTENCE_LEN)) begin
         if (pos_ff == POS_W'(4)) begin
            sum_in.kind = (req_data_byte == CH_G) ? KIND_GGA : KIND_UNKNOWN;
         end
         if (pos_ff == POS_W'(5) && req_data_byte == CH_C) begin
            sum_in.kind = KIND_RMC;
         end
         if (req_data_byte == CH_COMMA) begin
            if (field_ff < FIELD_W'(MAX_FIELDS - 1)) begin
               field_in = field_ff + 1'b1;
            end
            cif_in   = 7'd0;
            point_in = 1'b0;
            flen_in  = 3'd0;
         end else begin
            // Positional captures happen for any character.
            if (field_ff == FLD_TIME && cif_ff < 7'd6) begin
               sum_in.dt[{1'b0, cif_ff[2:0]}] = dig;
            end
            if (field_ff == FLD_DATE && cif_ff < 7'd6) begin
               sum_in.dt[4'd6 + {1'b0, cif_ff[2:0]}] = dig;
            end
            if (field_ff == FLD_STATUS && cif_ff == 7'd0) begin
               sum_in.fix = (req_data_byte == CH_A);
            end
            if (field_ff == FLD_NS && cif_ff == 7'd0) begin
               sum_in.hemi[0] = req_data_byte;
            end
            if (field_ff == FLD_EW && cif_ff == 7'd0) begin
               sum_in.hemi[1] = req_data_byte;
            end
            // Decimal point, sign, or a digit to accumulate.
            if (req_data_byte == CH_DOT && !point_ff) begin
               point_in = 1'b1;
            end else if (req_data_byte == CH_MINUS && cif_ff == 7'd0) begin
               if (field_ff == FLD_DATE) begin
                  sum_in.alt_neg = 1'b1;
               end
            end else begin
               for (int ax = 0; ax < 2; ax++) begin
                  if (field_ff == ((ax == 1) ? FLD_LON : FLD_LAT)) begin
                     if (!point_ff) begin
                        sum_in.whole[ax] = whole_digit(sum_ff.whole[ax], dig);
                     end else if (sum_ff.fdig[ax] < 3'd5) begin
                        sum_in.frac[ax] = 17'(sum_ff.frac[ax]) * 17'd10 + 17'(dig);
                        sum_in.fdig[ax] = sum_ff.fdig[ax] + 1'b1;
                     end
                  end
               end
               if (field_ff == FLD_SPEED) begin
                  sum_in.speed = hund_digit(sum_ff.speed, dig, point_ff, flen_ff, 20'd999999);
                  if (!point_ff) begin
                     sum_in.sats = sats_digit(sum_ff.sats, dig);
                  end
               end
               if (field_ff == FLD_COURSE) begin
                  sum_in.course = 16'(hund_digit(20'(sum_ff.course), dig, point_ff, flen_ff,
                                                 20'd35999));
               end
               if (field_ff == FLD_DATE) begin
                  sum_in.alt = tenth_digit(sum_ff.alt, dig, point_ff, flen_ff);
               end
               if (point_ff && flen_ff < 3'd7) begin
                  flen_in = flen_ff + 1'b1;
               end
            end
            if (cif_ff < 7'd127) begin
               cif_in = cif_ff + 1'b1;
            end
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   // Sentence state registers; the final character clears them.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_end_of_sentence)) begin
         sum_ff   <= '0;
         pos_ff   <= '0;
         field_ff <= '0;
         cif_ff   <= '0;
         point_ff <= 1'b0;
         flen_ff  <= '0;
      end else if (accept) begin
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         field_ff <= field_in;
         cif_ff   <= cif_in;
         point_ff <= point_in;
         flen_ff  <= flen_in;
      end
   end

   // Sentence queue toward the back end.
   assign q_push = accept && req_end_of_sentence;
   assign q_pop  = sum_pop && sum_out.valid;

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[q_wr_ff] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (q_push) begin
            q_wr_ff <= q_wr_ff + 1'b1;
         end
         if (q_pop) begin
            q_rd_ff <= q_rd_ff + 1'b1;
         end
         if (q_push && !q_pop) begin
            q_cnt_ff <= q_cnt_ff + 1'b1;
         end else if (q_pop && !q_push) begin
            q_cnt_ff <= q_cnt_ff - 1'b1;
         end
      end
   end

   assign sum_out.valid = (q_cnt_ff != '0);
   assign sum_out.data  = q_mem[q_rd_ff];

endmodule

/* src/nrgp_back.sv */
// ----------------------------------------------------------------------------
// NMEA sentence parser back end
// Turns a sentence summary into result records over two pipeline stages
// and holds them in a result queue.
// ----------------------------------------------------------------------------
`include "nmea_rmc_gga_sentence_parser_macros.svh"

module nrgp_back
   import nrgp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sum_port_type sum_in_port,
   output logic         sum_pop,
   output logic         empty,
   input  logic         pop,
   output rec_type      rsp_rec
);

   typedef struct packed {
      sum_type          base;
      logic [1:0][27:0] deg_prod;
      logic [1:0][22:0] scaled;
      logic [27:0]      speed_prod;
   } s1_type;

   // Scaled reciprocal of a power of ten, for exact division of values
   // below 2^24.
   function automatic logic [24:0] recip(logic [2:0] n);
      case (n)
         3'd1:    return 25'd26843546;
         3'd2:    return 25'd21474837;
         3'd3:    return 25'd17179870;
         3'd4:    return 25'd27487791;
         3'd5:    return 25'd21990233;
         default: return 25'd16777216;
      endcase
   endfunction

   function automatic logic [5:0] recip_shift(logic [2:0] n);
      case (n)
         3'd1:    return 6'd28;
         3'd2:    return 6'd31;
         3'd3:    return 6'd34;
         3'd4:    return 6'd38;
         3'd5:    return 6'd41;
         default: return 6'd24;
      endcase
   endfunction

   s1_type               s1_ff, s1_in;
   logic                 s1_valid_ff;
   rec_type              s2_rec0_ff, s2_rec1_ff, rec0_in, rec1_in;
   logic                 s2_valid_ff, s2_two_ff, two_in, phase_ff;
   logic                 advance1, advance2;
   logic [1:0][8:0]      deg;
   logic [1:0][6:0]      mins, secs;
   logic [1:0][47:0]     sec_prod;
   logic signed [28:0]   alt_s;

   rec_type              out_mem [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_rd_ff;
   logic [OUT_CNT_W-1:0] out_cnt_ff;
   logic                 out_full, out_push, out_pop;
   rec_type              push_rec;

   // Stage handshakes.
   assign out_full = (out_cnt_ff == OUT_CNT_W'(OUT_DEPTH));
   assign out_push = s2_valid_ff && !out_full;
   assign advance2 = !s2_valid_ff || (out_push && (phase_ff || !s2_two_ff));
   assign advance1 = !s1_valid_ff || advance2;
   assign sum_pop  = advance1 && sum_in_port.valid;

   // Stage one: the products.
   always_comb begin
      s1_in.base = sum_in_port.data;
      for (int ax = 0; ax < 2; ax++) begin
         s1_in.deg_prod[ax] = 28'(sum_in_port.data.whole[ax]) * 28'd5243;
         s1_in.scaled[ax]   = 23'(sum_in_port.data.frac[ax]) * 23'd60;
      end
      s1_in.speed_prod = 28'(sum_in_port.data.speed) * 28'd185;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance1) begin
         s1_valid_ff <= sum_in_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_pop) begin
         s1_ff <= s1_in;
      end
   end

   // Stage two: degrees, minutes and seconds of both axes.
   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         deg[ax]      = s1_ff.deg_prod[ax][27:19];
         mins[ax]     = 7'(s1_ff.base.whole[ax] - 15'(deg[ax]) * 15'd100);
         sec_prod[ax] = 48'(s1_ff.scaled[ax]) * 48'(recip(s1_ff.base.fdig[ax]));
         secs[ax]     = 7'(sec_prod[ax] >> recip_shift(s1_ff.base.fdig[ax]));
      end
      alt_s = s1_ff.base.alt_neg ? -$signed({8'b0, s1_ff.base.alt}) :
                                   $signed({8'b0, s1_ff.base.alt});
   end

   // Stage two: record formatting.
   always_comb begin
      rec0_in      = '0;
      rec1_in      = '0;
      rec0_in.last = 1'b1;
      two_in       = 1'b0;
      case (s1_ff.base.kind)
         KIND_RMC: begin
            if (s1_ff.base.fix) begin
               two_in         = 1'b1;
               rec0_in.record = REC_POSITION;
               rec0_in.status = STAT_OK;
               rec0_in.word_a = signed'(29'(deg[0]));
               rec0_in.word_b = 16'(mins[0]);
               rec0_in.word_c = secs[0];
               rec0_in.word_d = 10'(deg[1]);
               rec0_in.word_e = mins[1];
               rec0_in.word_f = secs[1];
               rec0_in.word_g = s1_ff.base.hemi[0];
               rec0_in.word_h = s1_ff.base.hemi[1];
               rec0_in.last   = 1'b0;
               rec1_in.record = REC_MOTION;
               rec1_in.status = STAT_OK;
               rec1_in.word_a = signed'(29'(s1_ff.speed_prod));
               rec1_in.word_b = s1_ff.base.course;
               rec1_in.word_c = 7'(s1_ff.base.dt[10]) * 7'd10 + 7'(s1_ff.base.dt[11]);
               rec1_in.word_d = 10'(s1_ff.base.dt[8]) * 10'd10 + 10'(s1_ff.base.dt[9]);
               rec1_in.word_e = 7'(s1_ff.base.dt[6]) * 7'd10 + 7'(s1_ff.base.dt[7]);
               rec1_in.word_f = 7'(s1_ff.base.dt[0]) * 7'd10 + 7'(s1_ff.base.dt[1]);
               rec1_in.word_g = 8'(s1_ff.base.dt[2]) * 8'd10 + 8'(s1_ff.base.dt[3]);
               rec1_in.word_h = 8'(s1_ff.base.dt[4]) * 8'd10 + 8'(s1_ff.base.dt[5]);
               rec1_in.last   = 1'b1;
            end else begin
               rec0_in.record = REC_REJECT;
               rec0_in.status = STAT_INVALID_FIX;
            end
         end
         KIND_GGA: begin
            rec0_in.record = REC_ALTITUDE;
            rec0_in.status = STAT_OK;
            rec0_in.word_a = alt_s;
            rec0_in.word_b = 16'(s1_ff.base.sats);
         end
         default: begin
            rec0_in.record = REC_REJECT;
            rec0_in.status = STAT_UNKNOWN_TYPE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
      end else begin
         if (advance2) begin
            s2_valid_ff <= s1_valid_ff;
            phase_ff    <= 1'b0;
         end else if (out_push && s2_two_ff && !phase_ff) begin
            phase_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance2 && s1_valid_ff) begin
         s2_rec0_ff <= rec0_in;
         s2_rec1_ff <= rec1_in;
         s2_two_ff  <= two_in;
      end
   end

   // Result queue.
   assign push_rec = phase_ff ? s2_rec1_ff : s2_rec0_ff;
   assign empty    = (out_cnt_ff == '0);
   assign out_pop  = pop && !empty;
   assign rsp_rec  = out_mem[out_rd_ff];

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem[out_wr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (out_push) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
         if (out_push && !out_pop) begin
            out_cnt_ff <= out_cnt_ff + 1'b1;
         end else if (out_pop && !out_push) begin
            out_cnt_ff <= out_cnt_ff - 1'b1;
         end
      end
   end

   // Checks on the record pipeline.
   `NRGP_ASSERT_NOW(a_out_cnt_bound, 1'b1, out_cnt_ff <= OUT_CNT_W'(OUT_DEPTH))
   `NRGP_ASSERT_NEXT(a_second_record, s2_valid_ff && s2_two_ff && !phase_ff && out_push, s2_valid_ff && phase_ff)
   `NRGP_ASSERT_NOW(a_only_position_not_last, out_push && !push_rec.last, push_rec.record == REC_POSITION)
   `NRGP_ASSERT_NEXT(a_stage1_holds, s1_valid_ff && !advance2, s1_valid_ff)

endmodule

/* src/nmea_rmc_gga_sentence_parser.sv */
// ----------------------------------------------------------------------------
// NMEA RMC/GGA sentence parser
// Parses RMC and GGA sentences one character per cycle while full is
// low and returns position, motion and altitude records.
//
//   Channel   Ports                         Moves a transaction when
//   -------   ---------------------------   --------------------------
//   request   push, full, req_*             push high and full low
//   response  empty, pop, rsp_*             pop high and empty low
//
// One character is taken every cycle while full is low; the front end
// updates its field state with each character. A finished sentence
// moves from the sentence queue through stage one and stage two to the
// result queue; an RMC sentence with a valid fix emits two records.
// full rises only when four finished sentences wait for the back end.
// Reset is synchronous and clears all sentence state and both queues.
// ----------------------------------------------------------------------------
module nmea_rmc_gga_sentence_parser
   import nrgp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_sentence,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_record,
   output logic [1:0]         rsp_status,
   output logic signed [28:0] rsp_word_a,
   output logic [15:0]        rsp_word_b,
   output logic [6:0]         rsp_word_c,
   output logic [9:0]         rsp_word_d,
   output logic [6:0]         rsp_word_e,
   output logic [6:0]         rsp_word_f,
   output logic [7:0]         rsp_word_g,
   output logic [7:0]         rsp_word_h,
   output logic               rsp_last_of_run
);

   sum_port_type sum_port;
   logic         sum_pop;
   rec_type      rec;

   // Character parser and sentence queue.
   nrgp_front u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_data_byte       (req_data_byte),
      .req_end_of_sentence (req_end_of_sentence),
      .sum_out             (sum_port),
      .sum_pop             (sum_pop)
   );

   // Record formatter and result queue.
   nrgp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .sum_in_port (sum_port),
      .sum_pop     (sum_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_rec     (rec)
   );

   // Result fields onto their ports.
   assign rsp_record      = rec.record;
   assign rsp_status      = rec.status;
   assign rsp_word_a      = rec.word_a;
   assign rsp_word_b      = rec.word_b;
   assign rsp_word_c      = rec.word_c;
   assign rsp_word_d      = rec.word_d;
   assign rsp_word_e      = rec.word_e;
   assign rsp_word_f      = rec.word_f;
   assign rsp_word_g      = rec.word_g;
   assign rsp_word_h      = rec.word_h;
   assign rsp_last_of_run = rec.last;

endmodule

/* tb/nrgp_checker.sv */
// ----------------------------------------------------------------------------
// NMEA sentence parser checker
// Watches the character and record channels of the parser. It keeps its own
// copy of the sentence state, predicts the records of each finished sentence
// and compares every record popped from the block, field by field.
// ----------------------------------------------------------------------------
module nrgp_checker
   import nrgp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               full,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_sentence,
   input  logic               empty,
   input  logic               pop,
   input  logic [1:0]         rsp_record,
   input  logic [1:0]         rsp_status,
   input  logic signed [28:0] rsp_word_a,
   input  logic [15:0]        rsp_word_b,
   input  logic [6:0]         rsp_word_c,
   input  logic [9:0]         rsp_word_d,
   input  logic [6:0]         rsp_word_e,
   input  logic [6:0]         rsp_word_f,
   input  logic [7:0]         rsp_word_g,
   input  logic [7:0]         rsp_word_h,
   input  logic               rsp_last_of_run,
   output int                 pending,
   output int                 errors
);

   // Sentence state as the parser should hold it.
   int unsigned pos, fld, cif;
   kind_type    kind;
   bit          fix;
   int unsigned cw[2], cf[2], cfd[2];
   logic [7:0]  hemi[2];
   int unsigned spd, crs, alt, sats;
   int unsigned dt[12];
   bit          pt, neg;
   int unsigned flen;

   // Records still owed by the block, oldest first.
   rec_type record_q[$];

   assign pending = record_q.size();

   function automatic longint unsigned pow_ten(int unsigned n);
      longint unsigned r;
      r = 1;
      for (int i = 0; i < n && i < 9; i++) r = r * 10;
      return r;
   endfunction

   function automatic void clear_sentence();
      pos = 0; fld = 0; cif = 0; kind = KIND_UNKNOWN; fix = 0;
      for (int i = 0; i < 2; i++) begin
         cw[i] = 0; cf[i] = 0; cfd[i] = 0; hemi[i] = 8'd0;
      end
      spd = 0; crs = 0; alt = 0; sats = 0;
      for (int i = 0; i < 12; i++) dt[i] = 0;
      pt = 0; neg = 0; flen = 0;
   endfunction

   // One decimal digit into a fixed-point value with keep fraction digits.
   function automatic int unsigned fixed_add(int unsigned v, int unsigned d,
                                             int unsigned keep, int unsigned limit);
      longint unsigned r;
      r = v;
      if (!pt) r = r * 10 + d * pow_ten(keep);
      else if (flen < keep) r = r + d * pow_ten(keep - 1 - flen);
      return (r > limit) ? limit : int'(r);
   endfunction

   function automatic void take_char(logic [7:0] b);
      int unsigned d, ax, s;
      d = (b >= CH_ZERO && b <= CH_NINE) ? b - CH_ZERO : 0;
      if (fld == FLD_TIME && cif < 6) dt[cif] = d;
      if (fld == FLD_DATE && cif < 6) dt[6 + cif] = d;
      if (fld == FLD_STATUS && cif == 0) fix = (b == CH_A);
      if ((fld == FLD_NS || fld == FLD_EW) && cif == 0) hemi[fld == FLD_EW] = b;
      if (b == CH_DOT && !pt) begin
         pt = 1;
         return;
      end
      if (b == CH_MINUS && cif == 0) begin
         if (fld == FLD_DATE) neg = 1;
         return;
      end
      if (fld == FLD_LAT || fld == FLD_LON) begin
         ax = (fld == FLD_LON);
         if (!pt) begin
            s = cw[ax] * 10 + d;
            cw[ax] = (s > 32767) ? 32767 : s;
         end else if (cfd[ax] < 5) begin
            cf[ax] = cf[ax] * 10 + d;
            cfd[ax]++;
         end
      end
      if (fld == FLD_SPEED) begin
         spd = fixed_add(spd, d, 2, 999999);
         if (!pt) begin
            s = sats * 10 + d;
            sats = (s > 127) ? 127 : s;
         end
      end
      if (fld == FLD_COURSE) crs = fixed_add(crs, d, 2, 35999);
      if (fld == FLD_DATE) alt = fixed_add(alt, d, 1, 999999);
      if (pt && flen < 7) flen++;
   endfunction

   function automatic int unsigned seconds_of(int ax);
      return int'((longint'(cf[ax]) * 60) / pow_ten(cfd[ax]));
   endfunction

   function automatic int unsigned pair(int i);
      return dt[i] * 10 + dt[i + 1];
   endfunction

   // Advance the state by one character and queue the records it finishes.
   function automatic void predict_char(logic [7:0] b, logic eos);
      rec_type r;
      if (pos < MAX_SENTENCE_LEN) begin
         if (pos == 4) kind = (b == CH_G) ? KIND_GGA : KIND_UNKNOWN;
         if (pos == 5 && b == CH_C) kind = KIND_RMC;
         if (b == CH_COMMA) begin
            if (fld < MAX_FIELDS - 1) fld++;
            cif = 0; pt = 0; flen = 0;
         end else begin
            take_char(b);
            if (cif < 127) cif++;
         end
         pos++;
      end
      if (!eos) return;
      r = '0;
      r.last = 1'b1;
      if (kind == KIND_RMC && fix) begin
         r.record = REC_POSITION; r.status = STAT_OK; r.last = 1'b0;
         r.word_a = 29'(cw[0] / 100); r.word_b = 16'(cw[0] % 100);
         r.word_c = 7'(seconds_of(0));
         r.word_d = 10'(cw[1] / 100); r.word_e = 7'(cw[1] % 100);
         r.word_f = 7'(seconds_of(1));
         r.word_g = hemi[0]; r.word_h = hemi[1];
         record_q.push_back(r);
         r.record = REC_MOTION; r.last = 1'b1;
         r.word_a = 29'(longint'(spd) * 185); r.word_b = 16'(crs);
         r.word_c = 7'(pair(10)); r.word_d = 10'(pair(8)); r.word_e = 7'(pair(6));
         r.word_f = 7'(pair(0)); r.word_g = 8'(pair(2)); r.word_h = 8'(pair(4));
      end else if (kind == KIND_RMC) begin
         r.record = REC_REJECT; r.status = STAT_INVALID_FIX;
      end else if (kind == KIND_GGA) begin
         r.record = REC_ALTITUDE; r.status = STAT_OK;
         r.word_a = neg ? 29'(-longint'(alt)) : 29'(alt);
         r.word_b = 16'(sats);
      end else begin
         r.record = REC_REJECT; r.status = STAT_UNKNOWN_TYPE;
      end
      record_q.push_back(r);
      clear_sentence();
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // Follow both channels on every clock edge.
   always @(posedge clock) begin
      rec_type e;
      if (reset) begin
         clear_sentence();
         errors = 0;
      end else begin
         if (pop && !empty) begin
            if (record_q.size() == 0) begin
               $display("%0t: record transaction with none expected", $realtime);
               errors++;
            end else begin
               e = record_q.pop_front();
               check_field("record", e.record, rsp_record);
               check_field("status", e.status, rsp_status);
               check_field("word_a", 32'(e.word_a[28:0]), 32'(rsp_word_a[28:0]));
               check_field("word_b", e.word_b, rsp_word_b);
               check_field("word_c", e.word_c, rsp_word_c);
               check_field("word_d", e.word_d, rsp_word_d);
               check_field("word_e", e.word_e, rsp_word_e);
               check_field("word_f", e.word_f, rsp_word_f);
               check_field("word_g", e.word_g, rsp_word_g);
               check_field("word_h", e.word_h, rsp_word_h);
               check_field("last_of_run", e.last, rsp_last_of_run);
            end
         end
         if (push && !full) predict_char(req_data_byte, req_end_of_sentence);
      end
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// NMEA sentence parser testbench
// Feeds short directed sentences, then random RMC, GGA, malformed, overlong
// and noise sentences with random gaps on both channels. A checker beside
// the parser predicts and compares all records; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
   import nrgp_pkg::*;
();

   localparam int ITEM_TARGET = 1650;
   localparam int CALM_AFTER  = 1400;
   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic [7:0]         req_data_byte = 8'd0;
   logic               req_end_of_sentence = 1'b0;
   logic               pop = 1'b0;
   logic               full, empty;
   logic [1:0]         rsp_record, rsp_status;
   logic signed [28:0] rsp_word_a;
   logic [15:0]        rsp_word_b;
   logic [6:0]         rsp_word_c, rsp_word_e, rsp_word_f;
   logic [9:0]         rsp_word_d;
   logic [7:0]         rsp_word_g, rsp_word_h;
   logic               rsp_last_of_run;
   int                 pending, errors;

   int          chars_sent = 0;
   int          cycles = 0;
   int          stall_left = 0;
   bit          calm = 0;
   bit          drained = 0;
   logic [7:0]  line_q[$];

   nmea_rmc_gga_sentence_parser u_dut (.*);
   nrgp_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cycle limit guards against a hung channel.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Record side: pops with random stall bursts until the calm tail.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Offer one character and hold it until the parser takes the transaction.
   task automatic put_char(logic [7:0] b, logic eos);
      if (!calm && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= b;
      req_end_of_sentence <= eos;
      forever begin
         @(negedge clock);
         if (!full) break;
      end
      @(posedge clock);
      chars_sent++;
      calm = (chars_sent > CALM_AFTER);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   task automatic add_digits(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) line_q.push_back(8'($urandom_range(32, 126)));
         else line_q.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
   endtask

   // A number field: optional sign, whole digits, optional point and fraction.
   task automatic add_number();
      if ($urandom_range(0, 5) == 0) line_q.push_back(CH_MINUS);
      add_digits($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 9));
      if ($urandom_range(0, 1)) begin
         line_q.push_back(CH_DOT);
         add_digits($urandom_range(0, 8));
         if ($urandom_range(0, 9) == 0) line_q.push_back(CH_DOT);
      end
   endtask

   task automatic send_line();
      for (int i = 0; i < line_q.size(); i++)
         put_char(line_q[i], i == line_q.size() - 1);
      line_q.delete();
   endtask

   // Build one random sentence into the line buffer.
   task automatic build_sentence();
      int shape, nf;
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
         repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(0, 6))
         0, 1, 2: add_text("$GPRMC");
         3, 4:    add_text("$GPGGA");
         5:       add_text("$GNRMC");
         default: repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      endcase
      nf = (shape == 1) ? $urandom_range(30, 45) : $urandom_range(0, 13);
      for (int f = 1; f <= nf; f++) begin
         line_q.push_back(CH_COMMA);
         if ($urandom_range(0, 9) == 0) continue;
         if (f == FLD_STATUS) add_text($urandom_range(0, 4) ? "A" : "V");
         else if (f == FLD_NS) add_text($urandom_range(0, 1) ? "N" : "S");
         else if (f == FLD_EW) add_text($urandom_range(0, 1) ? "E" : "W");
         else if (shape == 2) add_digits($urandom_range(5, 12));
         else add_number();
      end
      if (shape == 1) add_digits($urandom_range(20, 60));
      if ($urandom_range(0, 1)) add_text("*4F");
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: invalid fix, signed fractional altitude, unknown type.
      add_text("$GPRMC,,V");
      send_line();
      add_text("$GPGGA,,,,,,,9,,-.5");
      send_line();
      put_char(8'hFF, 1'b1);

      while (chars_sent < ITEM_TARGET) begin
         build_sentence();
         send_line();
         // Let the record side drain completely once mid-run.
         if (!drained && chars_sent > ITEM_TARGET / 2) begin
            drained = 1'b1;
            push <= 1'b0;
            @(negedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
      end
      push <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
